>>> rtl/memory_pool_health_monitor_defines.svh
// Assertion macros for the memory pool health monitor.
// Used by memory_pool_health_monitor.sv; depends on nothing.
`ifndef MEMORY_POOL_HEALTH_MONITOR_DEFINES_SVH
`define MEMORY_POOL_HEALTH_MONITOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MPHM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MPHM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mphm_pkg.sv
// Types and constants of the memory pool health monitor.
// No dependencies.
package mphm_pkg;

    localparam logic [1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [1:0] KIND_RESET    = 2'd1;
    localparam logic [1:0] KIND_CONSUME  = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic [2:0] REG_MIN_FREE_GATE   = 3'd0;
    localparam logic [2:0] REG_MIN_BLOCK_GATE  = 3'd1;
    localparam logic [2:0] REG_FRAG_SCALE_Q8   = 3'd2;
    localparam logic [2:0] REG_TRIGGER_PCT     = 3'd3;
    localparam logic [2:0] REG_CLEAR_PCT       = 3'd4;
    localparam logic [2:0] REG_BLOCK_LOW_BYTES = 3'd5;
    localparam logic [2:0] REG_COOLDOWN_MS     = 3'd6;
    localparam logic [2:0] REG_NOTICE_MS       = 3'd7;

    localparam logic [2:0] OP_FREE_PEAK  = 3'd0;
    localparam logic [2:0] OP_BLOCK_PEAK = 3'd1;
    localparam logic [2:0] OP_FREE_GATE  = 3'd2;
    localparam logic [2:0] OP_BLOCK_GATE = 3'd3;
    localparam logic [2:0] OP_PENALTY    = 3'd4;
    localparam logic [2:0] OP_END        = 3'd5;

    localparam logic [16:0] Q_ONE   = 17'd65536;
    localparam logic [6:0]  PCT_MAX = 7'd100;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PREP  = 8'b0000_0010,
        S_LOAD  = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_POST  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_ROUND = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

endpackage

>>> rtl/memory_pool_health_monitor.sv
// Memory pool health monitor top level: sequencer around one shared radix-2 divider.
// Depends on mphm_pkg and memory_pool_health_monitor_defines.svh.
//
// One item is taken at a time. A sample that passes the interval gate, and a
// peak reset, run up to five divisions through one restoring divider that
// produces one quotient bit per cycle over a POOL_BITS+24-bit dividend, then
// a multiply and a rounding step. Gated samples, consume items and reserved
// kinds skip the divider and go from S_PREP straight to S_FIN. A result
// register holds the last beat, so the next item is taken while it waits.
`include "memory_pool_health_monitor_defines.svh"
module memory_pool_health_monitor #(
    parameter int SAMPLE_INTERVAL_MS = 1000,
    parameter int NOTICE_MIN_DELTA   = 5,
    parameter int POOL_BITS          = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [2:0]                 i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // now_ms, free_bytes, largest_bytes, suppress_notice
    input  logic [((33+2*POOL_BITS+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  logic [1:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // health_pct, sample_taken, request_pending, request_granted, notice_showing,
    // notice_improved, notice_delta, min_free_seen, min_block_seen
    output logic [((19+2*POOL_BITS+7)/8)*8-1:0] m_axis_tdata
);
    localparam int P     = POOL_BITS;
    localparam int DW    = P + 24;
    localparam int DENW  = P + 16;
    localparam int CW    = $clog2(DW + 1);
    localparam int OUT_W = ((19 + 2*P + 7) / 8) * 8;

    mphm_pkg::t_state r_state, n_state;

    logic [23:0] r_min_free_gate, r_min_block_gate, r_block_low;
    logic [15:0] r_frag_scale;
    logic [6:0]  r_trigger_pct, r_clear_pct;
    logic [31:0] r_cooldown, r_notice_ms;

    logic [1:0]   r_kind;
    logic [31:0]  r_now;
    logic [P-1:0] r_fr, r_lg;
    logic         r_supp;

    logic [6:0]   r_health, r_notice_change;
    logic [31:0]  r_last_sample, r_notice_start, r_last_notice, r_last_reset;
    logic         r_notice_rise, r_notice_on, r_req;
    logic [P-1:0] r_peak_free, r_peak_block, r_low_free, r_low_block;
    logic         r_taken;

    logic [2:0]      r_op;
    logic [DENW-1:0] r_den, r_rem;
    logic [DW-1:0]   r_dvd;
    logic [17:0]     r_quo;
    logic            r_ovf;
    logic [CW-1:0]   r_cnt;
    logic [16:0]     r_hmin, r_pen, r_h;
    logic [6:0]      r_pct;

    logic            r_ovalid;
    logic [OUT_W-1:0] r_odata;

    logic [DENW:0]   w_rem_sh;
    logic            w_ge;
    logic [16:0]     w_ratio;
    logic [33:0]     w_prod;
    logic [23:0]     w_rnd;
    logic [7:0]      w_pct8;
    logic            w_gates_on;
    logic            w_out_free;
    logic            w_interval_ok;
    logic [P-1:0]    w_pf0, w_pb0;

    assign o_cfg_ready    = 1'b1;
    assign s_axis_tready  = (r_state == mphm_pkg::S_IDLE);
    assign m_axis_tvalid  = r_ovalid;
    assign m_axis_tdata   = r_odata;
    assign w_out_free     = !r_ovalid || m_axis_tready;
    assign w_gates_on     = (r_min_free_gate != 24'd0) && (r_min_block_gate != 24'd0);
    assign w_interval_ok  = (r_now - r_last_sample) >= 32'(SAMPLE_INTERVAL_MS);

    assign w_rem_sh = {r_rem, r_dvd[DW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_ratio  = (r_ovf || r_quo > {1'b0, mphm_pkg::Q_ONE}) ? mphm_pkg::Q_ONE
                                                                  : r_quo[16:0];
    assign w_prod   = r_hmin * r_pen;
    assign w_rnd    = {7'd0, r_h} * 24'd100 + 24'd32768;
    assign w_pct8   = w_rnd[23:16];

    assign w_pf0 = (r_peak_free == '0 || r_peak_block == '0) ? r_fr : r_peak_free;
    assign w_pb0 = (r_peak_free == '0 || r_peak_block == '0) ? r_lg : r_peak_block;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mphm_pkg::S_IDLE: begin
                if (s_axis_tvalid) n_state = mphm_pkg::S_PREP;
            end
            mphm_pkg::S_PREP: begin
                if ((r_kind == mphm_pkg::KIND_SAMPLE && w_interval_ok) ||
                    r_kind == mphm_pkg::KIND_RESET) begin
                    n_state = mphm_pkg::S_LOAD;
                end else begin
                    n_state = mphm_pkg::S_FIN;
                end
            end
            mphm_pkg::S_LOAD: begin
                priority if (r_op == mphm_pkg::OP_END) n_state = mphm_pkg::S_MUL;
                else if ((r_op == mphm_pkg::OP_FREE_PEAK && r_peak_free == '0) ||
                         (r_op == mphm_pkg::OP_BLOCK_PEAK && r_peak_block == '0) ||
                         ((r_op == mphm_pkg::OP_FREE_GATE ||
                           r_op == mphm_pkg::OP_BLOCK_GATE) && !w_gates_on) ||
                         (r_op == mphm_pkg::OP_PENALTY && r_fr == '0))
                    n_state = mphm_pkg::S_LOAD;
                else n_state = mphm_pkg::S_DIV;
            end
            mphm_pkg::S_DIV: begin
                if (r_cnt == CW'(1)) n_state = mphm_pkg::S_POST;
            end
            mphm_pkg::S_POST:  n_state = mphm_pkg::S_LOAD;
            mphm_pkg::S_MUL:   n_state = mphm_pkg::S_ROUND;
            mphm_pkg::S_ROUND: n_state = mphm_pkg::S_FIN;
            mphm_pkg::S_FIN: begin
                if (w_out_free) n_state = mphm_pkg::S_IDLE;
            end
            default: n_state = mphm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic [6:0]  v_dabs;
        logic        v_up, v_clow, v_req, v_on, v_rise, v_grant;
        logic [31:0] v_start;
        logic [6:0]  v_chg, v_hl;
        if (!i_rst_n) begin
            r_state          <= mphm_pkg::S_IDLE;
            r_min_free_gate  <= 24'd32768;
            r_min_block_gate <= 24'd16384;
            r_frag_scale     <= 16'd256;
            r_trigger_pct    <= 7'd40;
            r_clear_pct      <= 7'd60;
            r_block_low      <= 24'd16384;
            r_cooldown       <= 32'd0;
            r_notice_ms      <= 32'd2000;
            r_health         <= mphm_pkg::PCT_MAX;
            r_notice_change  <= 7'd0;
            r_last_sample    <= 32'd0;
            r_notice_start   <= 32'd0;
            r_last_notice    <= 32'd0;
            r_last_reset     <= 32'd0;
            r_notice_rise    <= 1'b0;
            r_notice_on      <= 1'b0;
            r_req            <= 1'b0;
            r_peak_free      <= '0;
            r_peak_block     <= '0;
            r_low_free       <= '0;
            r_low_block      <= '0;
            r_ovalid         <= 1'b0;
            r_taken          <= 1'b0;
            r_op             <= mphm_pkg::OP_FREE_PEAK;
            r_cnt            <= '0;
            r_hmin           <= mphm_pkg::Q_ONE;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mphm_pkg::REG_MIN_FREE_GATE:   r_min_free_gate  <= i_cfg_data[23:0];
                    mphm_pkg::REG_MIN_BLOCK_GATE:  r_min_block_gate <= i_cfg_data[23:0];
                    mphm_pkg::REG_FRAG_SCALE_Q8:   r_frag_scale     <= i_cfg_data[15:0];
                    mphm_pkg::REG_TRIGGER_PCT:     r_trigger_pct    <= i_cfg_data[6:0];
                    mphm_pkg::REG_CLEAR_PCT:       r_clear_pct      <= i_cfg_data[6:0];
                    mphm_pkg::REG_BLOCK_LOW_BYTES: r_block_low      <= i_cfg_data[23:0];
                    mphm_pkg::REG_COOLDOWN_MS:     r_cooldown       <= i_cfg_data;
                    mphm_pkg::REG_NOTICE_MS:       r_notice_ms      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tready && !(r_state == mphm_pkg::S_FIN && w_out_free))
                r_ovalid <= 1'b0;

            unique case (r_state)
                mphm_pkg::S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind <= s_axis_tuser;
                        r_now  <= s_axis_tdata[31:0];
                        r_fr   <= s_axis_tdata[32 +: P];
                        r_lg   <= s_axis_tdata[32+P +: P];
                        r_supp <= s_axis_tdata[32+2*P];
                    end
                end
                mphm_pkg::S_PREP: begin
                    r_taken <= (r_kind == mphm_pkg::KIND_SAMPLE) && w_interval_ok;
                    r_op    <= mphm_pkg::OP_FREE_PEAK;
                    r_hmin  <= mphm_pkg::Q_ONE;
                    r_pen   <= '0;
                    if (r_kind == mphm_pkg::KIND_SAMPLE && w_interval_ok) begin
                        r_last_sample <= r_now;
                        r_peak_free   <= (r_fr > w_pf0) ? r_fr : w_pf0;
                        r_peak_block  <= (r_lg > w_pb0) ? r_lg : w_pb0;
                        if (r_low_free == '0 || r_fr < r_low_free) r_low_free <= r_fr;
                        if (r_low_block == '0 || r_lg < r_low_block) r_low_block <= r_lg;
                    end else if (r_kind == mphm_pkg::KIND_RESET) begin
                        r_peak_free  <= r_fr;
                        r_peak_block <= r_lg;
                        r_low_free   <= r_fr;
                        r_low_block  <= r_lg;
                    end
                end
                mphm_pkg::S_LOAD: begin
                    r_rem <= '0;
                    r_quo <= '0;
                    r_ovf <= 1'b0;
                    r_cnt <= CW'(DW);
                    unique case (r_op)
                        mphm_pkg::OP_FREE_PEAK: begin
                            r_dvd <= DW'({r_fr, 16'd0});
                            r_den <= DENW'(r_peak_free);
                            if (r_peak_free == '0) r_hmin <= '0;
                        end
                        mphm_pkg::OP_BLOCK_PEAK: begin
                            r_dvd <= DW'({r_lg, 16'd0});
                            r_den <= DENW'(r_peak_block);
                            if (r_peak_block == '0) r_hmin <= '0;
                        end
                        mphm_pkg::OP_FREE_GATE: begin
                            r_dvd <= DW'({r_fr, 16'd0});
                            r_den <= DENW'(r_min_free_gate);
                        end
                        mphm_pkg::OP_BLOCK_GATE: begin
                            r_dvd <= DW'({r_lg, 16'd0});
                            r_den <= DENW'(r_min_block_gate);
                        end
                        mphm_pkg::OP_PENALTY: begin
                            r_dvd <= {r_lg, 24'd0};
                            r_den <= r_fr * ((r_frag_scale == 16'd0) ? 16'd1 : r_frag_scale);
                        end
                        default: ;
                    endcase
                    if (n_state == mphm_pkg::S_LOAD) r_op <= r_op + 3'd1;
                end
                mphm_pkg::S_DIV: begin
                    r_rem <= w_ge ? DENW'(w_rem_sh - {1'b0, r_den}) : DENW'(w_rem_sh);
                    r_dvd <= {r_dvd[DW-2:0], 1'b0};
                    r_quo <= {r_quo[16:0], w_ge};
                    r_ovf <= r_ovf | r_quo[17];
                    r_cnt <= r_cnt - CW'(1);
                end
                mphm_pkg::S_POST: begin
                    if (r_op == mphm_pkg::OP_PENALTY) r_pen <= w_ratio;
                    else if (w_ratio < r_hmin) r_hmin <= w_ratio;
                    r_op <= r_op + 3'd1;
                end
                mphm_pkg::S_MUL: r_h <= w_prod[32:16];
                mphm_pkg::S_ROUND: begin
                    r_pct <= (w_pct8 > 8'd100) ? mphm_pkg::PCT_MAX : w_pct8[6:0];
                end
                mphm_pkg::S_FIN: begin
                    if (w_out_free) begin
                        v_req   = r_req;
                        v_on    = r_notice_on;
                        v_rise  = r_notice_rise;
                        v_chg   = r_notice_change;
                        v_start = r_notice_start;
                        v_hl    = r_health;
                        v_grant = 1'b0;
                        v_up    = r_pct > r_health;
                        v_dabs  = v_up ? (r_pct - r_health) : (r_health - r_pct);
                        v_clow  = 32'(r_lg) < 32'(r_block_low);
                        if (r_kind == mphm_pkg::KIND_SAMPLE && r_taken) begin
                            v_hl = r_pct;
                            if (!r_req) begin
                                if (r_pct <= r_trigger_pct && v_clow &&
                                    (r_last_reset == 32'd0 ||
                                     (r_now - r_last_reset) >= r_cooldown))
                                    v_req = 1'b1;
                            end else if (r_pct >= r_clear_pct && !v_clow) begin
                                v_req = 1'b0;
                            end
                            if (v_dabs != 7'd0 && v_dabs >= 7'(NOTICE_MIN_DELTA) &&
                                (r_now - r_last_notice) >= r_notice_ms) begin
                                v_chg   = v_dabs;
                                v_rise  = v_up;
                                v_on    = 1'b1;
                                v_start = r_now;
                                r_last_notice <= r_now;
                            end
                        end else if (r_kind == mphm_pkg::KIND_RESET) begin
                            v_hl  = r_pct;
                            v_req = 1'b0;
                            r_last_reset <= r_now;
                            if (r_supp) begin
                                v_on  = 1'b0;
                                v_chg = 7'd0;
                                v_rise = 1'b0;
                                r_last_notice <= r_now;
                                r_last_sample <= r_now;
                            end
                        end else if (r_kind == mphm_pkg::KIND_CONSUME) begin
                            v_grant = r_req;
                            v_req   = 1'b0;
                        end
                        if (v_on && (r_now - v_start) >= r_notice_ms) v_on = 1'b0;
                        r_health        <= v_hl;
                        r_req           <= v_req;
                        r_notice_on     <= v_on;
                        r_notice_rise   <= v_rise;
                        r_notice_change <= v_chg;
                        r_notice_start  <= v_start;
                        r_ovalid        <= 1'b1;
                        r_odata <= OUT_W'({r_low_block, r_low_free, v_chg, v_rise, v_on,
                                           v_grant, v_req,
                                           (r_kind == mphm_pkg::KIND_SAMPLE) && r_taken,
                                           v_hl});
                    end
                end
                default: ;
            endcase
        end
    end

    `MPHM_ASSERT_IMP(a_health_range, i_clk, i_rst_n, 1'b1, r_health <= mphm_pkg::PCT_MAX,
        "health above 100")
    `MPHM_ASSERT_IMP(a_min_range, i_clk, i_rst_n, 1'b1, r_hmin <= mphm_pkg::Q_ONE,
        "ratio minimum above one")
    `MPHM_ASSERT_IMP(a_div_count, i_clk, i_rst_n, r_state == mphm_pkg::S_DIV,
        r_cnt != '0, "divider ran past its last bit")
    `MPHM_ASSERT_NXT(a_fin_out, i_clk, i_rst_n,
        r_state == mphm_pkg::S_FIN && w_out_free, r_ovalid,
        "finished item produced no beat")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for memory_pool_health_monitor: random and directed pool beats,
// results predicted in the bench and compared as a whole result. Depends on mphm_pkg.
`timescale 1ns / 1ps
module tb_top;

    localparam int PB = 24;
    localparam int IW = ((33 + 2 * PB + 7) / 8) * 8;
    localparam int OW = ((19 + 2 * PB + 7) / 8) * 8;
    localparam int GAP_MS = 1000;
    localparam int MIN_DELTA = 5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now;
        logic [23:0] fr;
        logic [23:0] lg;
        logic        sup;
    } pool_beat_t;

    typedef struct packed {
        logic [23:0] low_block;
        logic [23:0] low_free;
        logic [6:0]  delta;
        logic        improved;
        logic        showing;
        logic        granted;
        logic        pending;
        logic        taken;
        logic [6:0]  pct;
    } health_res_t;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic s_axis_tvalid = 0, s_axis_tready;
    logic [IW-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid, m_axis_tready = 0;
    logic [OW-1:0] m_axis_tdata;

    memory_pool_health_monitor uut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // predictor state
    logic [23:0] g_free, g_block, b_low;
    logic [15:0] g_scale;
    logic [6:0]  g_trig, g_clr;
    logic [31:0] g_cool, g_note;
    logic [6:0]  h_now, n_chg;
    logic [31:0] t_samp, t_nstart, t_nlast, t_rst;
    logic        n_rise, n_on, req;
    logic [23:0] pk_free, pk_block, lo_free, lo_block;

    health_res_t exp_q[$];
    pool_beat_t  beat_q[$];
    int errors = 0;
    int hold_cycles = 0;
    bit hold_req = 0, hold_done = 0;
    bit in_fire = 0;
    bit stim_done = 0;

    function automatic logic [16:0] q_div(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        if (b == 0) return 17'd0;
        r = (a << 16) / b;
        return r > 65536 ? 17'd65536 : r[16:0];
    endfunction

    function automatic logic [6:0] health_pct_of(logic [23:0] fr, logic [23:0] lg);
        logic [63:0] h, g, pen, sc, pct;
        h = 64'(q_div(64'(fr), 64'(pk_free)));
        g = 64'(q_div(64'(lg), 64'(pk_block)));
        if (g < h) h = g;
        if (g_free != 0 && g_block != 0) begin
            g = 64'(q_div(64'(fr), 64'(g_free)));
            if (g < h) h = g;
            g = 64'(q_div(64'(lg), 64'(g_block)));
            if (g < h) h = g;
        end
        sc = (g_scale == 0) ? 64'd1 : 64'(g_scale);
        if (fr == 0) pen = 0;
        else begin
            pen = (64'(lg) << 24) / (64'(fr) * sc);
            if (pen > 65536) pen = 65536;
        end
        h = (h * pen) >> 16;
        pct = (h * 100 + 32768) >> 16;
        if (pct > 100) pct = 100;
        return pct[6:0];
    endfunction

    task automatic predict_reset();
        g_free = 32768; g_block = 16384; g_scale = 256; g_trig = 40; g_clr = 60;
        b_low = 16384; g_cool = 0; g_note = 2000;
        h_now = 100; t_samp = 0; t_nstart = 0; t_nlast = 0; n_chg = 0; t_rst = 0;
        n_rise = 0; n_on = 0; req = 0;
        pk_free = 0; pk_block = 0; lo_free = 0; lo_block = 0;
    endtask

    task automatic predict_cfg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            mphm_pkg::REG_MIN_FREE_GATE:   g_free = v[23:0];
            mphm_pkg::REG_MIN_BLOCK_GATE:  g_block = v[23:0];
            mphm_pkg::REG_FRAG_SCALE_Q8:   g_scale = v[15:0];
            mphm_pkg::REG_TRIGGER_PCT:     g_trig = v[6:0];
            mphm_pkg::REG_CLEAR_PCT:       g_clr = v[6:0];
            mphm_pkg::REG_BLOCK_LOW_BYTES: b_low = v[23:0];
            mphm_pkg::REG_COOLDOWN_MS:     g_cool = v;
            mphm_pkg::REG_NOTICE_MS:       g_note = v;
            default: ;
        endcase
    endtask

    task automatic predict_health(pool_beat_t b);
        health_res_t r;
        logic [6:0] p, d;
        logic up, clow;
        r = '0;
        if (b.kind == mphm_pkg::KIND_SAMPLE) begin
            if (32'(b.now - t_samp) >= GAP_MS) begin
                r.taken = 1;
                t_samp = b.now;
                if (pk_free == 0 || pk_block == 0) begin
                    pk_free = b.fr; pk_block = b.lg;
                end
                if (lo_free == 0 || b.fr < lo_free) lo_free = b.fr;
                if (lo_block == 0 || b.lg < lo_block) lo_block = b.lg;
                if (b.fr > pk_free) pk_free = b.fr;
                if (b.lg > pk_block) pk_block = b.lg;
                p = health_pct_of(b.fr, b.lg);
                up = p > h_now;
                d = up ? p - h_now : h_now - p;
                h_now = p;
                clow = b.lg < b_low;
                if (!req) begin
                    if (p <= g_trig && clow && (t_rst == 0 || 32'(b.now - t_rst) >= g_cool))
                        req = 1;
                end else if (p >= g_clr && !clow) req = 0;
                if (d != 0 && d >= MIN_DELTA && 32'(b.now - t_nlast) >= g_note) begin
                    n_chg = d; n_rise = up; n_on = 1; t_nstart = b.now; t_nlast = b.now;
                end
            end
        end else if (b.kind == mphm_pkg::KIND_RESET) begin
            pk_free = b.fr; pk_block = b.lg; lo_free = b.fr; lo_block = b.lg;
            h_now = health_pct_of(b.fr, b.lg);
            req = 0;
            t_rst = b.now;
            if (b.sup) begin
                n_on = 0; n_chg = 0; n_rise = 0; t_nlast = b.now; t_samp = b.now;
            end
        end else if (b.kind == mphm_pkg::KIND_CONSUME) begin
            r.granted = req;
            req = 0;
        end
        if (n_on && 32'(b.now - t_nstart) >= g_note) n_on = 0;
        r.pct = h_now; r.pending = req; r.showing = n_on; r.improved = n_rise;
        r.delta = n_chg; r.low_free = lo_free; r.low_block = lo_block;
        exp_q.push_back(r);
    endtask

    // record input beats at the accepting edge
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (in_fire) begin
            predict_health(beat_q.pop_front());
        end
        if (s_axis_tvalid && !in_fire) begin
        end else if (gap_left > 0 || beat_q.size() == 0 || !i_rst_n) begin
            s_axis_tvalid <= 0;
            if (gap_left > 0) gap_left--;
        end else begin
            s_axis_tvalid <= 1;
            s_axis_tdata <= IW'({beat_q[0].sup, beat_q[0].lg, beat_q[0].fr, beat_q[0].now});
            s_axis_tuser <= beat_q[0].kind;
            if (burst_left > 0) burst_left--;
            else begin
                burst_left = $urandom_range(0, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
        end
    end

    // receiver stall pattern, plus long hold-off on request
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_cycles <= 3000;
            m_axis_tready <= 0;
        end else if (hold_cycles > 0) begin
            m_axis_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_phase[9]) m_axis_tready <= 1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            health_res_t got, want;
            got = m_axis_tdata[$bits(health_res_t)-1:0];
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = exp_q.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                    if (got.pct !== want.pct)
                        $display("%0t:  pct expected %0d actual %0d", $time, want.pct, got.pct);
                    errors++;
                end
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        predict_cfg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        while (beat_q.size() != 0 || s_axis_tvalid || exp_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    logic [31:0] clk_ms;
    task automatic push_beat(logic [1:0] k, logic [31:0] t, logic [23:0] f, logic [23:0] l,
                             logic s);
        pool_beat_t b;
        b.kind = k; b.now = t; b.fr = f; b.lg = l; b.sup = s;
        beat_q.push_back(b);
    endtask

    task automatic random_beats(int n);
        logic [23:0] f, l;
        logic s;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            s = 1'($urandom_range(0, 1));
            clk_ms += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 999)
                                                 : $urandom_range(1000, 3000);
            f = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 70000));
            l = ($urandom_range(0, 3) == 0) ? f : 24'($urandom_range(0, 32'(f)));
            if ($urandom_range(0, 19) == 0) l = 24'($urandom);
            if (r < 78) push_beat(mphm_pkg::KIND_SAMPLE, clk_ms, f, l, s);
            else if (r < 86) push_beat(mphm_pkg::KIND_RESET, clk_ms, f, l, s);
            else if (r < 97) push_beat(mphm_pkg::KIND_CONSUME, clk_ms, 24'($urandom),
                                       24'($urandom), s);
            else push_beat(mphm_pkg::KIND_RESERVED, clk_ms, 24'($urandom), 24'($urandom), s);
        end
    endtask

    initial begin
        predict_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, every kind, wrap, zero scale, zero-time reset
        push_beat(mphm_pkg::KIND_SAMPLE, 32'd0, 24'd0, 24'd0, 1'b0);
        push_beat(mphm_pkg::KIND_SAMPLE, 32'd1000, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        push_beat(mphm_pkg::KIND_SAMPLE, 32'd1500, 24'd100, 24'd50, 1'b0);
        push_beat(mphm_pkg::KIND_SAMPLE, 32'd2000, 24'd40000, 24'd100, 1'b0);
        push_beat(mphm_pkg::KIND_CONSUME, 32'd2100, 24'd0, 24'd0, 1'b0);
        push_beat(mphm_pkg::KIND_SAMPLE, 32'd3000, 24'd40000, 24'd0, 1'b0);
        push_beat(mphm_pkg::KIND_CONSUME, 32'd3100, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        push_beat(mphm_pkg::KIND_RESET, 32'd0, 24'd30000, 24'd20000, 1'b0);
        push_beat(mphm_pkg::KIND_SAMPLE, 32'd4000, 24'd1000, 24'd10, 1'b0);
        push_beat(mphm_pkg::KIND_RESERVED, 32'd9000, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        push_beat(mphm_pkg::KIND_RESET, 32'hFFFFFF00, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        push_beat(mphm_pkg::KIND_SAMPLE, 32'h00000400, 24'h800000, 24'h000001, 1'b0);
        push_beat(mphm_pkg::KIND_SAMPLE, 32'h00000900, 24'h800000, 24'h800000, 1'b1);
        push_beat(mphm_pkg::KIND_RESET, 32'h00001000, 24'd0, 24'd0, 1'b1);
        drain();
        cfg_write(mphm_pkg::REG_FRAG_SCALE_Q8, 32'd0);
        cfg_write(mphm_pkg::REG_MIN_FREE_GATE, 32'd0);
        push_beat(mphm_pkg::KIND_SAMPLE, 32'h00003000, 24'd5000, 24'd5000, 1'b0);
        push_beat(mphm_pkg::KIND_SAMPLE, 32'h00004000, 24'd5000, 24'd1, 1'b0);
        clk_ms = 32'h00005000;
        drain();

        // phases over several settings, extremes among them
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    cfg_write(mphm_pkg::REG_MIN_FREE_GATE, 32'd32768);
                    cfg_write(mphm_pkg::REG_FRAG_SCALE_Q8, 32'd256);
                end
                1: begin
                    cfg_write(mphm_pkg::REG_MIN_FREE_GATE, 32'hFFFFFF);
                    cfg_write(mphm_pkg::REG_MIN_BLOCK_GATE, 32'hFFFFFF);
                    cfg_write(mphm_pkg::REG_FRAG_SCALE_Q8, 32'hFFFF);
                    cfg_write(mphm_pkg::REG_TRIGGER_PCT, 32'd100);
                    cfg_write(mphm_pkg::REG_CLEAR_PCT, 32'd0);
                    cfg_write(mphm_pkg::REG_BLOCK_LOW_BYTES, 32'hFFFFFF);
                    cfg_write(mphm_pkg::REG_COOLDOWN_MS, 32'hFFFFFFFF);
                    cfg_write(mphm_pkg::REG_NOTICE_MS, 32'hFFFFFFFF);
                end
                2: begin
                    cfg_write(mphm_pkg::REG_MIN_BLOCK_GATE, 32'd0);
                    cfg_write(mphm_pkg::REG_FRAG_SCALE_Q8, 32'd1);
                    cfg_write(mphm_pkg::REG_TRIGGER_PCT, 32'd0);
                    cfg_write(mphm_pkg::REG_CLEAR_PCT, 32'd100);
                    cfg_write(mphm_pkg::REG_BLOCK_LOW_BYTES, 32'd0);
                    cfg_write(mphm_pkg::REG_COOLDOWN_MS, 32'd0);
                    cfg_write(mphm_pkg::REG_NOTICE_MS, 32'd0);
                end
                3: begin
                    cfg_write(mphm_pkg::REG_MIN_FREE_GATE, 32'd20000);
                    cfg_write(mphm_pkg::REG_MIN_BLOCK_GATE, 32'd8000);
                    cfg_write(mphm_pkg::REG_FRAG_SCALE_Q8, 32'd384);
                    cfg_write(mphm_pkg::REG_TRIGGER_PCT, 32'd60);
                    cfg_write(mphm_pkg::REG_CLEAR_PCT, 32'd70);
                    cfg_write(mphm_pkg::REG_BLOCK_LOW_BYTES, 32'd30000);
                    cfg_write(mphm_pkg::REG_COOLDOWN_MS, 32'd5000);
                    cfg_write(mphm_pkg::REG_NOTICE_MS, 32'd3000);
                end
                4: begin
                    cfg_write(mphm_pkg::REG_FRAG_SCALE_Q8, 32'd128);
                    cfg_write(mphm_pkg::REG_TRIGGER_PCT, 32'd90);
                    cfg_write(mphm_pkg::REG_COOLDOWN_MS, 32'd1500);
                end
                5: cfg_write(mphm_pkg::REG_BLOCK_LOW_BYTES, 32'd65535);
                default: cfg_write(mphm_pkg::REG_NOTICE_MS, 32'd500);
            endcase
            random_beats(ph == 4 ? 300 : 170);
            if (ph == 3) begin
                while (beat_q.size() > 150) @(posedge i_clk);
                @(posedge i_clk);
                hold_req = 1;
            end
            drain();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #10000000;
        $display("Verification failed");
        $finish;
    end
endmodule
